// ----- rtl/ldf_pkg.sv -----
`default_nettype none

package ldf_pkg;

  localparam int TIME_BITS_DEF     = 16;
  localparam int FRACTION_BITS_DEF = 16;

  localparam int CMD_W       = 2;
  localparam int LEVEL_IN_W  = 17;
  localparam int DURATION_W  = 16;
  localparam int DELTA_W     = 16;
  localparam int RAW_W       = 8;
  localparam int CFG_INDEX_W = 2;

  localparam logic [CMD_W-1:0] CMD_SET     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ANIMATE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK    = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_RAW_MIN = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_RAW_MAX = 2'd1;

  localparam logic [RAW_W-1:0] RAW_MIN_RST = 8'd0;
  localparam logic [RAW_W-1:0] RAW_MAX_RST = 8'd255;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADV,
    ST_DIV,
    ST_BL1,
    ST_BL2,
    ST_BLW,
    ST_LVL,
    ST_RAW1,
    ST_RAW2,
    ST_SET,
    ST_MW,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic issue;
    logic clear;
  } mac_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/ldf_div.sv -----
`default_nettype none

// restoring divider, one quotient bit per cycle; needs dividend < divisor
module ldf_div #(
  parameter int TIME_BITS     = ldf_pkg::TIME_BITS_DEF,
  parameter int FRACTION_BITS = ldf_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic [TIME_BITS-1:0]     dividend,
  input  wire logic [TIME_BITS-1:0]     divisor,
  output logic      [FRACTION_BITS-1:0] quotient,
  output logic                          done
);

  localparam int CNT_W = $clog2(FRACTION_BITS + 1);

  logic                     busy;
  logic [CNT_W-1:0]         cnt;
  logic [TIME_BITS-1:0]     rem;
  logic [TIME_BITS-1:0]     den;
  logic [TIME_BITS:0]       shifted;
  logic [TIME_BITS:0]       diff;
  logic                     fits;

  assign shifted = {rem, 1'b0};
  assign fits    = shifted >= {1'b0, den};
  assign diff    = shifted - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= dividend;
      den      <= divisor;
      cnt      <= CNT_W'(FRACTION_BITS);
      quotient <= '0;
    end else if (busy) begin
      rem      <= fits ? diff[TIME_BITS-1:0] : shifted[TIME_BITS-1:0];
      quotient <= {quotient[FRACTION_BITS-2:0], fits};
      cnt      <= cnt - CNT_W'(1);
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ldf_mac.sv -----
`default_nettype none

// multiply, register the product, then accumulate it into acc
module ldf_mac #(
  parameter int OP_W = ldf_pkg::FRACTION_BITS_DEF + 1
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire ldf_pkg::mac_ctl_t    ctl,
  input  wire logic [OP_W-1:0]      a,
  input  wire logic [OP_W-1:0]      b,
  output logic      [2*OP_W-1:0]    acc
);

  logic [2*OP_W-1:0] prod;
  logic              pend;
  logic              pend_clr;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend     <= 1'b0;
      pend_clr <= 1'b0;
    end else begin
      pend     <= ctl.issue;
      pend_clr <= ctl.clear;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.issue) begin
      prod <= a * b;
    end
    if (pend) begin
      acc <= (pend_clr ? '0 : acc) + prod;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/led_duty_fade_ramp_top.sv -----
// LED duty fade engine. Levels are unsigned fractions with FRACTION_BITS fraction bits
// (full level = 2^FRACTION_BITS). A set word jumps to a level and returns
// level*raw_max; an animate word starts a linear ramp and returns its first
// duty at once; a tick word advances a running ramp and returns the new duty
// (a tick while no ramp runs returns nothing). The block takes one word at a
// time. When the ramp has not yet reached its end, an animate or tick word
// also goes through the bit-serial ramp-fraction divider. All products go
// through one shared multiply-accumulate unit. The result sits in an output
// register, so a new word is taken as soon as the sequencer is back in idle.
// The last state waits while the previous result is still held. raw_min and
// raw_max must be written only while the block is idle; the block itself
// does not enforce this.

`default_nettype none

module led_duty_fade_ramp_top #(
  parameter int TIME_BITS     = ldf_pkg::TIME_BITS_DEF,
  parameter int FRACTION_BITS = ldf_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_write,
  input  wire logic [ldf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [ldf_pkg::RAW_W-1:0]       cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [ldf_pkg::CMD_W-1:0]       command,
  input  wire logic [ldf_pkg::LEVEL_IN_W-1:0]  level,
  input  wire logic [ldf_pkg::LEVEL_IN_W-1:0]  from_level,
  input  wire logic                            from_current,
  input  wire logic [ldf_pkg::DURATION_W-1:0]  duration,
  input  wire logic [ldf_pkg::DELTA_W-1:0]     time_delta,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic      [ldf_pkg::RAW_W-1:0]       raw_duty,
  output logic                                 ramping,
  output logic                                 force_off
);

  localparam int LW    = FRACTION_BITS + 1;
  localparam int CW    = (LW > ldf_pkg::LEVEL_IN_W) ? LW : ldf_pkg::LEVEL_IN_W;
  localparam int SUM_W = ((TIME_BITS > ldf_pkg::DELTA_W) ? TIME_BITS : ldf_pkg::DELTA_W) + 1;
  localparam logic [LW-1:0]        ONE      = LW'(1) << FRACTION_BITS;
  localparam logic [CW-1:0]        ONE_C    = CW'(ONE);
  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;
  localparam logic [SUM_W-1:0]     SUM_MAX  = SUM_W'(TIME_MAX);

  ldf_pkg::state_t state;
  ldf_pkg::state_t state_next;

  logic [ldf_pkg::RAW_W-1:0] raw_min;
  logic [ldf_pkg::RAW_W-1:0] raw_max;
  logic [LW-1:0]             start_level;
  logic [LW-1:0]             target_level;
  logic [LW-1:0]             current_level;
  logic [LW-1:0]             frac;
  logic [TIME_BITS-1:0]      elapsed;
  logic [TIME_BITS-1:0]      ramp_length;
  logic                      active;

  logic [CW-1:0]             lvl_ext;
  logic [CW-1:0]             from_ext;
  logic [LW-1:0]             lvl_clamped;
  logic [LW-1:0]             from_clamped;
  logic [SUM_W-1:0]          sum;
  logic [TIME_BITS-1:0]      elapsed_sat;
  logic                      accept;
  logic                      out_free;
  logic [ldf_pkg::RAW_W-1:0] raw_new;

  ldf_pkg::mac_ctl_t         mac_ctl;
  logic [LW-1:0]             mac_a;
  logic [LW-1:0]             mac_b;
  logic [2*LW-1:0]           acc;
  logic                      div_start;
  logic                      div_done;
  logic [FRACTION_BITS-1:0]  div_quot;

  assign lvl_ext      = CW'(level);
  assign from_ext     = CW'(from_level);
  assign lvl_clamped  = (lvl_ext > ONE_C) ? ONE : LW'(lvl_ext);
  assign from_clamped = (from_ext > ONE_C) ? ONE : LW'(from_ext);
  assign sum          = SUM_W'(elapsed) + SUM_W'(time_delta);
  assign elapsed_sat  = (sum > SUM_MAX) ? TIME_MAX : TIME_BITS'(sum);
  assign in_stall     = (state != ldf_pkg::ST_IDLE);
  assign accept       = in_valid && !in_stall;
  assign out_free     = !out_valid || !out_stall;
  assign raw_new      = acc[FRACTION_BITS +: ldf_pkg::RAW_W];

  ldf_mac #(
    .OP_W (LW)
  ) u_mac (
    .clk (clk),
    .rst (rst),
    .ctl (mac_ctl),
    .a   (mac_a),
    .b   (mac_b),
    .acc (acc)
  );

  ldf_div #(
    .TIME_BITS     (TIME_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (elapsed),
    .divisor  (ramp_length),
    .quotient (div_quot),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ldf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mac_ctl    = '0;
    mac_a      = '0;
    mac_b      = '0;
    div_start  = 1'b0;
    unique case (state)
      ldf_pkg::ST_IDLE: begin
        if (accept) begin
          priority case (command)
            ldf_pkg::CMD_SET:     state_next = ldf_pkg::ST_SET;
            ldf_pkg::CMD_ANIMATE: state_next = ldf_pkg::ST_ADV;
            ldf_pkg::CMD_TICK:    if (active) state_next = ldf_pkg::ST_ADV;
            default: ;
          endcase
        end
      end
      ldf_pkg::ST_ADV: begin
        if (elapsed >= ramp_length) begin
          state_next = ldf_pkg::ST_BL1;
        end else begin
          div_start  = 1'b1;
          state_next = ldf_pkg::ST_DIV;
        end
      end
      ldf_pkg::ST_DIV: begin
        if (div_done) state_next = ldf_pkg::ST_BL1;
      end
      ldf_pkg::ST_BL1: begin
        mac_ctl    = '{issue: 1'b1, clear: 1'b1};
        mac_a      = start_level;
        mac_b      = ONE - frac;
        state_next = ldf_pkg::ST_BL2;
      end
      ldf_pkg::ST_BL2: begin
        mac_ctl    = '{issue: 1'b1, clear: 1'b0};
        mac_a      = target_level;
        mac_b      = frac;
        state_next = ldf_pkg::ST_BLW;
      end
      ldf_pkg::ST_BLW: state_next = ldf_pkg::ST_LVL;
      ldf_pkg::ST_LVL: state_next = ldf_pkg::ST_RAW1;
      ldf_pkg::ST_RAW1: begin
        mac_ctl    = '{issue: 1'b1, clear: 1'b1};
        mac_a      = LW'(raw_min);
        mac_b      = ONE - current_level;
        state_next = ldf_pkg::ST_RAW2;
      end
      ldf_pkg::ST_RAW2: begin
        mac_ctl    = '{issue: 1'b1, clear: 1'b0};
        mac_a      = LW'(raw_max);
        mac_b      = current_level;
        state_next = ldf_pkg::ST_MW;
      end
      ldf_pkg::ST_SET: begin
        mac_ctl    = '{issue: 1'b1, clear: 1'b1};
        mac_a      = current_level;
        mac_b      = LW'(raw_max);
        state_next = ldf_pkg::ST_MW;
      end
      ldf_pkg::ST_MW: state_next = ldf_pkg::ST_FIN;
      ldf_pkg::ST_FIN: begin
        if (out_free) state_next = ldf_pkg::ST_IDLE;
      end
      default: state_next = ldf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_min <= ldf_pkg::RAW_MIN_RST;
      raw_max <= ldf_pkg::RAW_MAX_RST;
    end else if (cfg_write) begin
      if (cfg_index == ldf_pkg::REG_RAW_MIN) raw_min <= cfg_data;
      if (cfg_index == ldf_pkg::REG_RAW_MAX) raw_max <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_level   <= '0;
      target_level  <= '0;
      current_level <= '0;
      elapsed       <= '0;
      ramp_length   <= '0;
      active        <= 1'b0;
    end else begin
      unique case (state)
        ldf_pkg::ST_IDLE: begin
          if (accept) begin
            priority case (command)
              ldf_pkg::CMD_SET: begin
                start_level   <= lvl_clamped;
                target_level  <= lvl_clamped;
                current_level <= lvl_clamped;
                active        <= 1'b0;
              end
              ldf_pkg::CMD_ANIMATE: begin
                start_level   <= from_current ? current_level : from_clamped;
                current_level <= from_current ? current_level : from_clamped;
                target_level  <= lvl_clamped;
                elapsed       <= '0;
                ramp_length   <= TIME_BITS'(duration);
                active        <= 1'b1;
              end
              ldf_pkg::CMD_TICK: begin
                if (active) elapsed <= elapsed_sat;
              end
              default: ;
            endcase
          end
        end
        ldf_pkg::ST_ADV: begin
          if (elapsed >= ramp_length) active <= 1'b0;
        end
        ldf_pkg::ST_LVL: current_level <= acc[FRACTION_BITS +: LW];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ldf_pkg::ST_ADV && elapsed >= ramp_length) begin
      frac <= ONE;
    end else if (state == ldf_pkg::ST_DIV && div_done) begin
      frac <= LW'(div_quot);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ldf_pkg::ST_FIN && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ldf_pkg::ST_FIN && out_free) begin
      raw_duty  <= raw_new;
      ramping   <= active;
      force_off <= (raw_new == '0);
    end
  end

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ldf_pkg::*;

  localparam int PERIOD = 20;
  localparam int FRAC = FRACTION_BITS_DEF;
  localparam longint unsigned ONE = 64'd1 << FRAC;
  localparam longint unsigned TIME_TOP = (64'd1 << TIME_BITS_DEF) - 1;
  localparam logic [LEVEL_IN_W-1:0] LEVEL_FULL = 17'h10000;
  localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;
  localparam int SETTLE = 64;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    logic [CMD_W-1:0]      cmd;
    logic [LEVEL_IN_W-1:0] lvl;
    logic [LEVEL_IN_W-1:0] from_lvl;
    logic                  from_cur;
    logic [DURATION_W-1:0] dur;
    logic [DELTA_W-1:0]    dt;
  } word_t;

  typedef struct {
    logic [RAW_W-1:0] duty;
    logic             moving;
    logic             off;
  } duty_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [RAW_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [CMD_W-1:0] command = '0;
  logic [LEVEL_IN_W-1:0] level = '0;
  logic [LEVEL_IN_W-1:0] from_level = '0;
  logic from_current = 1'b0;
  logic [DURATION_W-1:0] duration = '0;
  logic [DELTA_W-1:0] time_delta = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [RAW_W-1:0] raw_duty;
  logic ramping;
  logic force_off;

  // predictor state
  logic [LEVEL_IN_W-1:0] lvl_start = '0;
  logic [LEVEL_IN_W-1:0] lvl_target = '0;
  logic [LEVEL_IN_W-1:0] lvl_now = '0;
  logic [DELTA_W-1:0] time_in = '0;
  logic [DURATION_W-1:0] ramp_len = '0;
  logic ramp_on = 1'b0;
  logic [RAW_W-1:0] duty_lo = RAW_MIN_RST;
  logic [RAW_W-1:0] duty_hi = RAW_MAX_RST;

  word_t word_q[$];
  duty_t duty_due[$];
  word_t word_cur;
  int gap_left = 0;
  int calm_in = 0;
  int stall_left = 0;
  int hold_left = 0;
  int calm_out = 0;
  int words_taken = 0;
  int results_seen = 0;
  int reg_writes = 0;
  int fails = 0;
  int cycles = 0;
  int gen_dur = 0;

  led_duty_fade_ramp_top dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .command(command),
    .level(level),
    .from_level(from_level),
    .from_current(from_current),
    .duration(duration),
    .time_delta(time_delta),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .raw_duty(raw_duty),
    .ramping(ramping),
    .force_off(force_off)
  );

  always #(PERIOD / 2) clk = ~clk;

  function automatic logic [LEVEL_IN_W-1:0] sat_level(input logic [LEVEL_IN_W-1:0] v);
    return (v > LEVEL_FULL) ? LEVEL_FULL : v;
  endfunction

  function automatic longint unsigned mix(input longint unsigned a, input longint unsigned b,
                                          input longint unsigned t);
    return (a * (ONE - t) + b * t) >> FRAC;
  endfunction

  task automatic push_duty(input longint unsigned raw);
    duty_t e;
    e.duty = raw[RAW_W-1:0];
    e.moving = ramp_on;
    e.off = (raw[RAW_W-1:0] == '0);
    duty_due.push_back(e);
  endtask

  task automatic ramp_step(input longint unsigned dt);
    longint unsigned sum;
    longint unsigned frac;
    sum = 64'(time_in) + dt;
    time_in = (sum > TIME_TOP) ? TIME_TOP[DELTA_W-1:0] : sum[DELTA_W-1:0];
    if (time_in >= ramp_len) begin
      frac = ONE;
      ramp_on = 1'b0;
    end else begin
      frac = (64'(time_in) << FRAC) / 64'(ramp_len);
    end
    lvl_now = LEVEL_IN_W'(mix(64'(lvl_start), 64'(lvl_target), frac));
    push_duty(mix(64'(duty_lo), 64'(duty_hi), 64'(lvl_now)));
  endtask

  task automatic fade_predict(input word_t w);
    logic [LEVEL_IN_W-1:0] tgt;
    logic [LEVEL_IN_W-1:0] from;
    tgt = sat_level(w.lvl);
    from = sat_level(w.from_lvl);
    case (w.cmd)
      CMD_SET: begin
        lvl_start = tgt;
        lvl_target = tgt;
        lvl_now = tgt;
        ramp_on = 1'b0;
        push_duty((64'(tgt) * 64'(duty_hi)) >> FRAC);
      end
      CMD_ANIMATE: begin
        if (w.from_cur) from = lvl_now;
        time_in = '0;
        ramp_len = w.dur;
        lvl_start = from;
        lvl_target = tgt;
        lvl_now = from;
        ramp_on = 1'b1;
        ramp_step(64'd0);
      end
      CMD_TICK: begin
        if (ramp_on) ramp_step(64'(w.dt));
      end
      default: ;
    endcase
  endtask

  // sender
  always @(posedge clk) begin : drive
    logic valid_nxt;
    valid_nxt = in_valid;
    if (!rst && !(in_valid && in_stall)) begin
      if (in_valid) begin
        fade_predict(word_cur);
        words_taken++;
        if (calm_in > 0) begin
          calm_in--;
          gap_left = 0;
        end else begin
          gap_left = $urandom_range(0, 3);
          if ($urandom_range(0, 7) == 0) calm_in = 20;
        end
      end
      valid_nxt = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (word_q.size() != 0) begin
        word_cur = word_q.pop_front();
        command <= word_cur.cmd;
        level <= word_cur.lvl;
        from_level <= word_cur.from_lvl;
        from_current <= word_cur.from_cur;
        duration <= word_cur.dur;
        time_delta <= word_cur.dt;
        valid_nxt = 1'b1;
      end
    end
    in_valid <= valid_nxt;
  end

  // receiver and checker
  always @(posedge clk) begin : watch
    logic stall_nxt;
    duty_t e;
    stall_nxt = 1'b0;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (duty_due.size() == 0) begin
          $error("raw_duty: no word expected, got %0d", raw_duty);
          fails++;
        end else begin
          e = duty_due.pop_front();
          if (raw_duty !== e.duty) begin
            $error("raw_duty: expected %0d, got %0d", e.duty, raw_duty);
            fails++;
          end
          if (ramping !== e.moving) begin
            $error("ramping: expected %0d, got %0d", e.moving, ramping);
            fails++;
          end
          if (force_off !== e.off) begin
            $error("force_off: expected %0d, got %0d", e.off, force_off);
            fails++;
          end
        end
        results_seen++;
        // long hold-off so the block backs up into its input
        if (results_seen == 40 || results_seen == 250) begin
          hold_left = HOLD_CYCLES;
        end else if (calm_out > 0) begin
          calm_out--;
          stall_left = 0;
        end else begin
          stall_left = $urandom_range(0, 3);
          if ($urandom_range(0, 7) == 0) calm_out = 20;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        stall_nxt = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        stall_nxt = 1'b1;
      end
    end
    out_stall <= stall_nxt;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic add_word(input logic [CMD_W-1:0] cmd, input logic [LEVEL_IN_W-1:0] lvl,
                          input logic [LEVEL_IN_W-1:0] from_lvl, input logic from_cur,
                          input logic [DURATION_W-1:0] dur, input logic [DELTA_W-1:0] dt);
    word_t w;
    w.cmd = cmd;
    w.lvl = lvl;
    w.from_lvl = from_lvl;
    w.from_cur = from_cur;
    w.dur = dur;
    w.dt = dt;
    word_q.push_back(w);
  endtask

  function automatic logic [LEVEL_IN_W-1:0] rand_level();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return LEVEL_FULL;
      2: return LEVEL_IN_W'($urandom);
      default: return LEVEL_IN_W'($urandom_range(0, 65536));
    endcase
  endfunction

  task automatic queue_random(input int n);
    word_t w;
    int pick;
    int made;
    made = 0;
    while (made < n) begin
      w.cmd = CMD_TICK;
      w.lvl = rand_level();
      w.from_lvl = rand_level();
      w.from_cur = 1'($urandom_range(0, 1));
      w.dur = DURATION_W'($urandom);
      w.dt = DELTA_W'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        w.cmd = CMD_SET;
      end else if (pick < 32) begin
        w.cmd = CMD_ANIMATE;
        case ($urandom_range(0, 4))
          0: w.dur = '0;
          1: w.dur = DURATION_W'($urandom_range(1, 16));
          2: w.dur = DURATION_W'($urandom_range(17, 1024));
          3: w.dur = DURATION_W'($urandom_range(1025, 65535));
          default: ;
        endcase
        gen_dur = int'(w.dur);
      end else if (pick < 97) begin
        // mostly small steps so ramps last several ticks
        if ($urandom_range(0, 9) != 0) w.dt = DELTA_W'($urandom_range(0, gen_dur / 3 + 1));
      end else begin
        w.cmd = CMD_NONE;
      end
      word_q.push_back(w);
      if (w.cmd != CMD_NONE) made++;
    end
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [RAW_W-1:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      REG_RAW_MIN: duty_lo = data;
      REG_RAW_MAX: duty_hi = data;
      default: ;
    endcase
    reg_writes++;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(negedge clk); while (word_q.size() != 0 || in_valid || duty_due.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  initial begin
    logic [RAW_W-1:0] lo;
    logic [RAW_W-1:0] hi;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    add_word(CMD_SET, '0, '0, 1'b0, '0, '0);
    add_word(CMD_SET, LEVEL_FULL, '0, 1'b0, '0, '0);
    add_word(CMD_SET, 17'h1FFFF, '0, 1'b0, '0, '0);
    add_word(CMD_SET, 17'h08000, 17'h1FFFF, 1'b1, 16'hFFFF, 16'hFFFF);
    add_word(CMD_TICK, '0, '0, 1'b0, '0, 16'd5);
    add_word(CMD_NONE, 17'h1FFFF, 17'h1FFFF, 1'b1, 16'hFFFF, 16'hFFFF);
    add_word(CMD_ANIMATE, LEVEL_FULL, '0, 1'b0, '0, '0);
    add_word(CMD_ANIMATE, '0, 17'h1FFFF, 1'b0, 16'd100, '0);
    add_word(CMD_TICK, '0, '0, 1'b0, '0, '0);
    add_word(CMD_TICK, '0, '0, 1'b0, '0, 16'd37);
    add_word(CMD_TICK, '0, '0, 1'b0, '0, 16'hFFFF);
    add_word(CMD_TICK, '0, '0, 1'b0, '0, 16'd1);
    add_word(CMD_ANIMATE, LEVEL_FULL, '0, 1'b1, 16'hFFFF, '0);
    add_word(CMD_TICK, '0, '0, 1'b0, '0, 16'd40000);
    add_word(CMD_TICK, '0, '0, 1'b0, '0, 16'd40000);
    add_word(CMD_ANIMATE, 17'd12345, LEVEL_FULL, 1'b0, 16'd1, '0);
    add_word(CMD_TICK, '0, '0, 1'b0, '0, '0);
    add_word(CMD_TICK, '0, '0, 1'b0, '0, 16'd1);
    add_word(CMD_ANIMATE, '0, '0, 1'b1, 16'd3, '0);
    add_word(CMD_TICK, '0, '0, 1'b0, '0, 16'd1);
    add_word(CMD_TICK, '0, '0, 1'b0, '0, 16'd1);
    add_word(CMD_TICK, '0, '0, 1'b0, '0, 16'd1);
    add_word(CMD_SET, 17'h0FFFF, '0, 1'b0, '0, '0);
    wait_idle();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin lo = 8'd0; hi = 8'd255; end
        1: begin lo = 8'd255; hi = 8'd0; end
        2: begin lo = 8'd0; hi = 8'd0; end
        3: begin lo = 8'd255; hi = 8'd255; end
        default: begin lo = RAW_W'($urandom); hi = RAW_W'($urandom); end
      endcase
      write_reg(REG_RAW_MIN, lo);
      write_reg(REG_RAW_MAX, hi);
      if (p == 3) begin
        write_reg(REG_SPARE_A, RAW_W'($urandom));
        write_reg(REG_SPARE_B, RAW_W'($urandom));
      end
      @(negedge clk);
      queue_random((p == 0) ? 140 : ((p < 4) ? 60 : 40));
      wait_idle();
    end

    $display("covered %0d command words, %0d duty words, %0d register writes over 7 settings",
             words_taken, results_seen, reg_writes);
    if (fails == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/ldf_pkg.sv
rtl/ldf_div.sv
rtl/ldf_mac.sv
rtl/led_duty_fade_ramp_top.sv
verif/tb.sv
